// File: rtl/core/fntc_pkg.sv
// shared constants, types and helper functions for the frequency to note block
// no dependencies
package fntc_pkg;

   localparam int OCTAVE_TOP = 12;
   localparam int LOG_FRAC   = 24;
   localparam int FREQ_W     = 32;
   localparam int A4_W       = 23;
   localparam int EXP_W      = 5;
   localparam int LOG_W      = EXP_W + LOG_FRAC;
   localparam int CENTS_W    = 15;
   localparam int CNT_W      = $clog2(LOG_FRAC);

   localparam logic [A4_W-1:0] A4_RESET = A4_W'(7208960);

   typedef enum logic [1:0] {
      RL_IDLE,
      RL_NORM,
      RL_SQUARE
   } rl_state_type;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [LOG_W-1:0] log2;
   } log_res_type;

   function automatic logic [EXP_W-1:0] msb_index(input logic [FREQ_W-1:0] x);
      logic [EXP_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < FREQ_W; i++) begin
         if (x[i]) idx = EXP_W'(i);
      end
      return idx;
   endfunction

   // one squaring round: {fraction bit, next mantissa}
   function automatic logic [FREQ_W:0] square_step(input logic [FREQ_W-1:0] m);
      logic [2*FREQ_W-1:0] p;
      logic [FREQ_W:0]     q;
      p = m * m;
      q = p[2*FREQ_W-1:FREQ_W-1];
      if (q[FREQ_W]) return {1'b1, q[FREQ_W:1]};
      else return {1'b0, q[FREQ_W-1:0]};
   endfunction

endpackage

// File: rtl/core/frequency_to_note_and_cents_top.sv
// top level of the frequency to note classifier
// depends on fntc_pkg, fntc_log2_pipe, fntc_ref_log2, fntc_note_map
//
// req channel: req_valid/req_stall with req_frequency in unsigned Q18.14 hz.
// rsp channel: rsp_valid/rsp_stall with rsp_in_range, rsp_semitone, rsp_octave
// and rsp_cents (signed Q7.8, within +-50 cents).
// csr channel: csr_valid/csr_ready with csr_data, the A4 pitch in Q9.14 hz.
// csr_ready is high only while no request is in flight, and req_stall is high
// while csr_valid is high, so a write never overlaps a request.
// from request to response the path runs through one normalize stage, 24
// squaring stages of the log2 (one 32x32 multiplier each) and three stages of
// note mapping. a new request is taken every cycle while req_stall is low.
// after reset and after each csr write the log2 of the reference pitch is
// worked out on one shared multiplier; req_stall is high during that time.
// reset loads 440 hz.
// a stalled response holds the whole pipeline, so req_stall follows rsp_stall
// while a response waits; nothing is dropped or repeated.
module frequency_to_note_and_cents_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fntc_pkg::FREQ_W-1:0]        req_frequency,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_in_range,
   output logic [3:0]                         rsp_semitone,
   output logic [3:0]                         rsp_octave,
   output logic signed [fntc_pkg::CENTS_W-1:0] rsp_cents,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fntc_pkg::A4_W-1:0]          csr_data
);
   import fntc_pkg::*;

   logic             advance;
   logic             busy;
   logic             ref_zero;
   logic [LOG_W-1:0] ref_log2;
   log_res_type      log_res;
   logic             in_acc;
   logic             out_acc;
   logic [4:0]       inflight_ff, inflight_in;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || busy || csr_valid;
   assign csr_ready = (inflight_ff == '0);
   assign in_acc    = req_valid && !req_stall;
   assign out_acc   = rsp_valid && !rsp_stall;

   // requests accepted and not yet answered
   always_comb begin
      inflight_in = inflight_ff + 5'(in_acc) - 5'(out_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   fntc_ref_log2 u_ref (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_data  (csr_data),
      .busy     (busy),
      .ref_zero (ref_zero),
      .ref_log2 (ref_log2)
   );

   fntc_log2_pipe u_log (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (in_acc),
      .in_x     (req_frequency),
      .out_res  (log_res)
   );

   fntc_note_map u_map (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_res       (log_res),
      .ref_zero     (ref_zero),
      .ref_log2     (ref_log2),
      .out_valid    (rsp_valid),
      .out_in_range (rsp_in_range),
      .out_semitone (rsp_semitone),
      .out_octave   (rsp_octave),
      .out_cents    (rsp_cents)
   );

endmodule

// File: rtl/core/fntc_log2_pipe.sv
// pipelined fixed-point log2 of the request frequency, one squaring per stage
// depends on fntc_pkg
module fntc_log2_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [fntc_pkg::FREQ_W-1:0] in_x,
   output fntc_pkg::log_res_type       out_res
);
   import fntc_pkg::*;

   logic                v_ff [0:LOG_FRAC];
   logic                z_ff [0:LOG_FRAC];
   logic [EXP_W-1:0]    e_ff [0:LOG_FRAC];
   logic [FREQ_W-1:0]   m_ff [0:LOG_FRAC];
   logic [LOG_FRAC-1:0] f_ff [0:LOG_FRAC];
   logic [FREQ_W:0]     sq_in [0:LOG_FRAC-1];
   logic [EXP_W-1:0]    top_in;

   assign top_in = msb_index(in_x);

   always_comb begin
      for (int i = 0; i < LOG_FRAC; i++) sq_in[i] = square_step(m_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LOG_FRAC; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < LOG_FRAC; i++) v_ff[i+1] <= v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z_ff[0] <= (in_x == '0);
         e_ff[0] <= top_in;
         m_ff[0] <= in_x << (EXP_W'(FREQ_W-1) - top_in);
         f_ff[0] <= '0;
         for (int i = 0; i < LOG_FRAC; i++) begin
            z_ff[i+1] <= z_ff[i];
            e_ff[i+1] <= e_ff[i];
            m_ff[i+1] <= sq_in[i][FREQ_W-1:0];
            f_ff[i+1] <= {f_ff[i][LOG_FRAC-2:0], sq_in[i][FREQ_W]};
         end
      end
   end

   assign out_res.valid = v_ff[LOG_FRAC];
   assign out_res.zero  = z_ff[LOG_FRAC];
   assign out_res.log2  = {e_ff[LOG_FRAC], f_ff[LOG_FRAC]};

endmodule

// File: rtl/core/fntc_ref_log2.sv
// reference pitch register and iterative log2 of it, rerun after reset and each write
// depends on fntc_pkg
module fntc_ref_log2 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [fntc_pkg::A4_W-1:0]  wr_data,
   output logic                       busy,
   output logic                       ref_zero,
   output logic [fntc_pkg::LOG_W-1:0] ref_log2
);
   import fntc_pkg::*;

   rl_state_type        state_ff, state_in;
   logic [A4_W-1:0]     a4_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [FREQ_W-1:0]   m_ff;
   logic [EXP_W-1:0]    e_ff;
   logic [LOG_FRAC-1:0] f_ff;
   logic                z_ff;
   logic [FREQ_W-1:0]   a4_wide;
   logic [EXP_W-1:0]    top_in;
   logic [FREQ_W:0]     sq_in;

   assign a4_wide = FREQ_W'(a4_ff);
   assign top_in  = msb_index(a4_wide);
   assign sq_in   = square_step(m_ff);

   always_comb begin
      state_in = state_ff;
      if (wr_en) state_in = RL_NORM;
      else begin
         unique case (state_ff)
            RL_IDLE:   state_in = RL_IDLE;
            RL_NORM:   state_in = RL_SQUARE;
            RL_SQUARE: if (cnt_ff == CNT_W'(LOG_FRAC-1)) state_in = RL_IDLE;
            default:   state_in = RL_IDLE;
         endcase
      end
   end

   always_comb begin
      busy = (state_ff != RL_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RL_NORM;
         a4_ff    <= A4_RESET;
      end else begin
         state_ff <= state_in;
         if (wr_en) a4_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == RL_NORM) begin
         z_ff   <= (a4_ff == '0);
         e_ff   <= top_in;
         m_ff   <= a4_wide << (EXP_W'(FREQ_W-1) - top_in);
         f_ff   <= '0;
         cnt_ff <= '0;
      end else if (state_ff == RL_SQUARE) begin
         m_ff   <= sq_in[FREQ_W-1:0];
         f_ff   <= {f_ff[LOG_FRAC-2:0], sq_in[FREQ_W]};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign ref_zero = z_ff;
   assign ref_log2 = {e_ff, f_ff};

endmodule

// File: rtl/core/fntc_note_map.sv
// semitone distance, range check, rounding to a note and cents, three stages
// depends on fntc_pkg
module fntc_note_map (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  fntc_pkg::log_res_type       in_res,
   input  logic                        ref_zero,
   input  logic [fntc_pkg::LOG_W-1:0]  ref_log2,
   output logic                        out_valid,
   output logic                        out_in_range,
   output logic [3:0]                  out_semitone,
   output logic [3:0]                  out_octave,
   output logic signed [fntc_pkg::CENTS_W-1:0] out_cents
);
   import fntc_pkg::*;

   localparam int S_W = LOG_W + 5;
   localparam int D_W = LOG_FRAC + 2;
   localparam int V_W = D_W + 16;
   localparam logic signed [S_W-1:0] S_LO   = -(S_W'(115) <<< (LOG_FRAC-1));
   localparam logic signed [S_W-1:0] S_HI   = S_W'(24*OCTAVE_TOP-91) <<< (LOG_FRAC-1);
   localparam logic signed [7:0]     K_MAX  = 8'(12*OCTAVE_TOP+3-49);
   localparam logic signed [S_W:0]   S_HALF = (S_W+1)'(1) <<< (LOG_FRAC-1);
   localparam logic signed [V_W-1:0] V_HALF = V_W'(1) <<< (LOG_FRAC-1);
   localparam logic signed [17:0]    C_MAX  = 18'sd12800;

   logic                  a_v_ff, b_v_ff, c_v_ff;
   logic                  a_ok_ff, b_ok_ff;
   logic signed [S_W-1:0] s_ff;
   logic signed [7:0]     k_ff;
   logic signed [D_W-1:0] d_ff;
   logic                  c_rng_ff;
   logic [3:0]            c_semi_ff, c_oct_ff;
   logic signed [CENTS_W-1:0] c_cents_ff;

   logic signed [S_W-1:0] diff_in;
   logic signed [S_W:0]   ks_in;
   logic signed [7:0]     kr_in, k_in;
   logic signed [S_W-1:0] d_in;
   logic signed [V_W-1:0] v_in;
   logic signed [17:0]    c_in;
   logic signed [CENTS_W-1:0] cc_in;
   logic [7:0]            u_in;
   logic [15:0]           q_prod;
   logic [3:0]            q_in, r_in;

   assign diff_in = S_W'(in_res.log2) - S_W'(ref_log2);

   always_comb begin
      ks_in = ((S_W+1)'(s_ff) + S_HALF) >>> LOG_FRAC;
      kr_in = ks_in[7:0];
      k_in  = (kr_in > K_MAX) ? K_MAX : kr_in;
      d_in  = s_ff - (S_W'(k_in) <<< LOG_FRAC);
   end

   always_comb begin
      v_in   = V_W'(d_ff) * V_W'(25600) + V_HALF;
      c_in   = 18'(v_in >>> LOG_FRAC);
      if (c_in > C_MAX) cc_in = CENTS_W'(C_MAX);
      else if (c_in < -C_MAX) cc_in = CENTS_W'(-C_MAX);
      else cc_in = c_in[CENTS_W-1:0];
      u_in   = 8'(k_ff + 8'sd57);
      q_prod = 16'(u_in) * 16'd171;
      q_in   = q_prod[14:11];
      r_in   = 4'(u_in - 8'(q_in) * 8'd12);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= in_res.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ok_ff <= !in_res.zero && !ref_zero;
         s_ff    <= (diff_in <<< 3) + (diff_in <<< 2);
         b_ok_ff <= a_ok_ff && (s_ff >= S_LO) && (s_ff <= S_HI);
         k_ff    <= k_in;
         d_ff    <= d_in[D_W-1:0];
         c_rng_ff   <= b_ok_ff;
         c_semi_ff  <= b_ok_ff ? r_in : 4'd0;
         c_oct_ff   <= b_ok_ff ? q_in : 4'd0;
         c_cents_ff <= b_ok_ff ? cc_in : '0;
      end
   end

   assign out_valid    = c_v_ff;
   assign out_in_range = c_rng_ff;
   assign out_semitone = c_semi_ff;
   assign out_octave   = c_oct_ff;
   assign out_cents    = c_cents_ff;

endmodule

// File: rtl/core/fntc_checker.sv
// port level checks of the frequency to note block, bound to the top level
// depends on frequency_to_note_and_cents_top
module fntc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_in_range,
   input logic [3:0]        rsp_semitone,
   input logic [3:0]        rsp_octave,
   input logic signed [14:0] rsp_cents
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |->
         rsp_semitone == 4'd0 && rsp_octave == 4'd0 && rsp_cents == 15'sd0)
      else $error("out of range response with nonzero fields");

   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_range |->
         rsp_semitone <= 4'd11 && rsp_cents <= 15'sd12800 && rsp_cents >= -15'sd12800)
      else $error("response fields out of bounds");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cents) && $stable(rsp_octave))
      else $error("stalled response changed");

endmodule

bind frequency_to_note_and_cents_top fntc_checker u_fntc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_in_range (rsp_in_range),
   .rsp_semitone (rsp_semitone),
   .rsp_octave   (rsp_octave),
   .rsp_cents    (rsp_cents)
);
